/* rtl/palfb_pkg.sv */
`default_nettype none

package palfb_pkg;

  localparam int COLOR_W = 24;
  localparam int INDEX_W = 8;
  localparam int CFG_DATA_W = 9;

  // Palette limit in nibble mode.
  localparam logic [INDEX_W-1:0] NIBBLE_LIMIT = 8'd15;

  localparam logic [1:0] FUNC_PLOT = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_FILL = 2'd2;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_LOOKUP,
    S_SEARCH,
    S_FWRITE,
    S_FMERGE,
    S_FREAD,
    S_RDIDX,
    S_RDPAL,
    S_FILL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/palette_indexed_framebuffer.sv */
// Indexed-colour framebuffer with a palette that is built as colours arrive.
// Input channel (in_valid/in_ready) carries one operation per transfer: func
// selects plot, read or fill; x_pos, y_pos and pixel_color are its operands.
// Output channel (out_valid/out_ready) returns exactly one result per
// operation: read_color, color_index, accepted and palette_full.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// mode, image width and image height; it is always ready and must only be
// used while no operation is in flight.
// One operation is worked on at a time. A plot first checks the recent-colour
// cache; on a miss it searches the palette one entry per cycle through the
// palette memory's read port; nibble mode adds a read-modify-write of the
// frame byte. A read goes through address multiply, frame read and palette
// read. A fill sweeps the frame memory one byte a cycle. Reset clears the
// palette count, the recent-colour cache and the result valid flag, and
// sets mode to 255 colours at 256 by 256 pixels. The frame holds nothing
// meaningful until the first fill. If the receiver stalls, the result
// waits in its register and the next operation may already be transferred
// in; its result is held back until the first is taken.
`default_nettype none

module palette_indexed_framebuffer #(
  parameter int PALETTE_ENTRIES = 255,
  parameter int FRAME_BYTES     = 65536,
  parameter int MAX_DIM         = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [15:0] x_pos,
  input  wire logic [15:0] y_pos,
  input  wire logic [23:0] pixel_color,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      read_color,
  output logic [7:0]       color_index,
  output logic             accepted,
  output logic             palette_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int PA_W  = $clog2(PALETTE_ENTRIES);
  localparam int FA_W  = $clog2(FRAME_BYTES);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int PIX_W = $clog2(MAX_DIM * MAX_DIM);

  // Configuration registers.
  logic       mode;
  logic [8:0] width_cfg;
  logic [8:0] height_cfg;

  // Operation and working registers.
  palfb_pkg::state_t state, state_next;
  logic [1:0]  func_r, func_r_next;
  logic [15:0] x_r, x_r_next;
  logic [15:0] y_r, y_r_next;
  logic [23:0] color_r, color_r_next;
  logic [PIX_W-1:0] pix, pix_next;
  logic [7:0]  idx, idx_next;
  logic        acc, acc_next;
  logic        pal_ok, pal_ok_next;
  logic [7:0]  srch_i, srch_i_next;
  logic [7:0]  cmp_idx, cmp_idx_next;
  logic        cmp_pend, cmp_pend_next;
  logic [FA_W-1:0] sweep, sweep_next;

  // Palette bookkeeping and the one-entry cache of the most recent colour.
  logic [7:0]  count, count_next;
  logic [23:0] recent_color, recent_color_next;
  logic        recent_valid, recent_valid_next;
  logic [7:0]  recent_index, recent_index_next;

  // Result register.
  logic        out_valid_next;
  logic [23:0] read_color_next;
  logic [7:0]  color_index_next;
  logic        accepted_next;
  logic        palette_full_next;

  // Memory ports.
  logic            pal_we;
  logic [PA_W-1:0] pal_waddr, pal_raddr;
  logic [23:0]     pal_wdata, pal_rdata;
  logic            frm_we;
  logic [FA_W-1:0] frm_waddr, frm_raddr;
  logic [7:0]      frm_wdata, frm_rdata;

  // Derived address terms.
  logic [DIM_W-1:0] w_eff, h_eff, cx, cy;
  logic             in_image;
  logic [31:0]      baddr;
  logic             in_rng;
  logic [7:0]       lim;
  logic [7:0]       fidx;

  function automatic logic [DIM_W-1:0] dim_eff(input logic [8:0] d);
    logic [DIM_W-1:0] r;
    if (d == 9'd0) begin
      r = DIM_W'(1);
    end else if (32'(d) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  palfb_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  palfb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frm_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  assign in_ready  = (state == palfb_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b1;
      width_cfg  <= 9'd256;
      height_cfg <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        palfb_pkg::CFG_MODE:   mode       <= cfg_data[0];
        palfb_pkg::CFG_WIDTH:  width_cfg  <= cfg_data;
        palfb_pkg::CFG_HEIGHT: height_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff    = dim_eff(width_cfg);
    h_eff    = dim_eff(height_cfg);
    in_image = (32'(x_r) < 32'(w_eff)) && (32'(y_r) < 32'(h_eff));
    cx       = (32'(x_r) < 32'(w_eff)) ? DIM_W'(x_r) : w_eff - DIM_W'(1);
    cy       = (32'(y_r) < 32'(h_eff)) ? DIM_W'(y_r) : h_eff - DIM_W'(1);
    baddr    = mode ? 32'(pix) : (32'(pix) >> 1);
    in_rng   = baddr < 32'(FRAME_BYTES);
    lim      = mode ? 8'(PALETTE_ENTRIES) : palfb_pkg::NIBBLE_LIMIT;
    if (!in_rng) begin
      fidx = 8'd0;
    end else if (mode) begin
      fidx = frm_rdata;
    end else if (pix[0]) begin
      fidx = {4'd0, frm_rdata[7:4]};
    end else begin
      fidx = {4'd0, frm_rdata[3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= palfb_pkg::S_IDLE;
      count        <= '0;
      recent_color <= '0;
      recent_valid <= 1'b0;
      recent_index <= '0;
      out_valid    <= 1'b0;
      cmp_pend     <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      recent_color <= recent_color_next;
      recent_valid <= recent_valid_next;
      recent_index <= recent_index_next;
      out_valid    <= out_valid_next;
      cmp_pend     <= cmp_pend_next;
    end
    func_r       <= func_r_next;
    x_r          <= x_r_next;
    y_r          <= y_r_next;
    color_r      <= color_r_next;
    pix          <= pix_next;
    idx          <= idx_next;
    acc          <= acc_next;
    pal_ok       <= pal_ok_next;
    srch_i       <= srch_i_next;
    cmp_idx      <= cmp_idx_next;
    sweep        <= sweep_next;
    read_color   <= read_color_next;
    color_index  <= color_index_next;
    accepted     <= accepted_next;
    palette_full <= palette_full_next;
  end

  always_comb begin
    state_next        = state;
    func_r_next       = func_r;
    x_r_next          = x_r;
    y_r_next          = y_r;
    color_r_next      = color_r;
    pix_next          = pix;
    idx_next          = idx;
    acc_next          = acc;
    pal_ok_next       = pal_ok;
    srch_i_next       = srch_i;
    cmp_idx_next      = cmp_idx;
    cmp_pend_next     = cmp_pend;
    sweep_next        = sweep;
    count_next        = count;
    recent_color_next = recent_color;
    recent_valid_next = recent_valid;
    recent_index_next = recent_index;
    out_valid_next    = out_valid && !out_ready;
    read_color_next   = read_color;
    color_index_next  = color_index;
    accepted_next     = accepted;
    palette_full_next = palette_full;
    pal_we            = 1'b0;
    pal_waddr         = count[PA_W-1:0];
    pal_wdata         = color_r;
    pal_raddr         = srch_i[PA_W-1:0];
    frm_we            = 1'b0;
    frm_waddr         = baddr[FA_W-1:0];
    frm_wdata         = idx;
    frm_raddr         = baddr[FA_W-1:0];

    unique case (state)
      palfb_pkg::S_IDLE: begin
        if (in_valid) begin
          func_r_next  = func;
          x_r_next     = x_pos;
          y_r_next     = y_pos;
          color_r_next = pixel_color;
          state_next   = palfb_pkg::S_ADDR;
        end
      end

      palfb_pkg::S_ADDR: begin
        pix_next = PIX_W'({{DIM_W{1'b0}}, cy} * {{DIM_W{1'b0}}, w_eff}
                          + {{DIM_W{1'b0}}, cx});
        idx_next = 8'd0;
        acc_next = 1'b0;
        pal_ok_next = 1'b0;
        unique case (func_r)
          palfb_pkg::FUNC_PLOT: begin
            if (in_image) begin
              acc_next   = 1'b1;
              state_next = palfb_pkg::S_LOOKUP;
            end else begin
              state_next = palfb_pkg::S_DONE;
            end
          end
          palfb_pkg::FUNC_READ: begin
            acc_next   = 1'b1;
            state_next = palfb_pkg::S_FREAD;
          end
          palfb_pkg::FUNC_FILL: begin
            // The palette restarts with the fill colour as its only entry.
            pal_we            = 1'b1;
            pal_waddr         = '0;
            count_next        = 8'd1;
            recent_color_next = color_r;
            recent_valid_next = 1'b1;
            recent_index_next = 8'd0;
            acc_next          = 1'b1;
            sweep_next        = '0;
            state_next        = palfb_pkg::S_FILL;
          end
          default: begin
            state_next = palfb_pkg::S_DONE;
          end
        endcase
      end

      palfb_pkg::S_LOOKUP: begin
        if (recent_valid && color_r == recent_color) begin
          idx_next   = recent_index;
          state_next = palfb_pkg::S_FWRITE;
        end else begin
          srch_i_next   = 8'd0;
          cmp_pend_next = 1'b0;
          state_next    = palfb_pkg::S_SEARCH;
        end
      end

      palfb_pkg::S_SEARCH: begin
        // One palette read is issued per cycle; its data is compared once the
        // read port has registered it, while the next read is already under way.
        if (cmp_pend && pal_rdata == color_r) begin
          cmp_pend_next     = 1'b0;
          recent_color_next = color_r;
          recent_index_next = cmp_idx;
          recent_valid_next = 1'b1;
          idx_next          = cmp_idx;
          state_next        = palfb_pkg::S_FWRITE;
        end else if (srch_i < count) begin
          cmp_pend_next = 1'b1;
          cmp_idx_next  = srch_i;
          srch_i_next   = srch_i + 8'd1;
        end else begin
          cmp_pend_next = 1'b0;
          if (count < lim) begin
            pal_we            = 1'b1;
            recent_color_next = color_r;
            recent_index_next = count;
            recent_valid_next = 1'b1;
            idx_next          = count;
            count_next        = count + 8'd1;
          end else begin
            idx_next = recent_index;
          end
          state_next = palfb_pkg::S_FWRITE;
        end
      end

      palfb_pkg::S_FWRITE: begin
        if (mode) begin
          frm_we     = in_rng;
          state_next = palfb_pkg::S_DONE;
        end else begin
          state_next = palfb_pkg::S_FMERGE;
        end
      end

      palfb_pkg::S_FMERGE: begin
        frm_we    = in_rng;
        frm_wdata = pix[0] ? {idx[3:0], frm_rdata[3:0]} : {frm_rdata[7:4], idx[3:0]};
        state_next = palfb_pkg::S_DONE;
      end

      palfb_pkg::S_FREAD: begin
        state_next = palfb_pkg::S_RDIDX;
      end

      palfb_pkg::S_RDIDX: begin
        idx_next    = fidx;
        pal_raddr   = fidx[PA_W-1:0];
        pal_ok_next = fidx < count;
        state_next  = palfb_pkg::S_RDPAL;
      end

      palfb_pkg::S_RDPAL: begin
        // The palette read port moves on next cycle, so the colour is kept
        // in the operand register until the result is loaded.
        color_r_next = pal_ok ? pal_rdata : 24'd0;
        state_next   = palfb_pkg::S_DONE;
      end

      palfb_pkg::S_FILL: begin
        frm_we    = 1'b1;
        frm_waddr = sweep;
        frm_wdata = 8'd0;
        sweep_next = sweep + FA_W'(1);
        if (32'(sweep) == 32'(FRAME_BYTES - 1)) begin
          state_next = palfb_pkg::S_DONE;
        end
      end

      palfb_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next    = 1'b1;
          read_color_next   = (func_r == palfb_pkg::FUNC_READ) ? color_r : 24'd0;
          color_index_next  = idx;
          accepted_next     = acc;
          palette_full_next = count >= lim;
          state_next        = palfb_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = palfb_pkg::S_IDLE;
      end
    endcase
  end

  // The palette never grows beyond its memory.
  assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(PALETTE_ENTRIES))
    else $error("palette count beyond palette depth");

  // Palette entries are only written when a colour is entered.
  assert property (@(posedge clk) disable iff (rst)
    pal_we |-> (state == palfb_pkg::S_ADDR || state == palfb_pkg::S_SEARCH))
    else $error("palette written outside lookup or fill");

  // A completed search leaves the cache holding the colour that was looked up,
  // unless the palette was full and the colour was not in it.
  assert property (@(posedge clk) disable iff (rst)
    (state == palfb_pkg::S_SEARCH && state_next == palfb_pkg::S_FWRITE && count < lim)
    |=> (recent_valid && recent_color == color_r && recent_index == idx))
    else $error("cache not updated after palette search");

  // A new result is only loaded once the previous one has been taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

/* rtl/palfb_ram.sv */
`default_nettype none

module palfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
